// ===== hdl/group_reverse_reorder_macros.svh =====
// ---------------------------------------------------------------------------
// group reverse reorder assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef GROUP_REVERSE_REORDER_MACROS_SVH
`define GROUP_REVERSE_REORDER_MACROS_SVH

// same-cycle implication, disabled during reset
`define GRR_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define GRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/grr_pkg.sv =====
// ---------------------------------------------------------------------------
// grr_pkg
// shared constants and controller/datapath interface types
// ---------------------------------------------------------------------------
`default_nettype none

package grr_pkg;

  localparam int MAX_GROUP_DEF    = 16;
  localparam int DATA_WIDTH_DEF   = 32;
  localparam int CFG_W            = 5;
  localparam int GROUP_SIZE_RESET = 3;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic step;    // load the next result into the output register
  } grr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic emit_req;    // current input completes a group or ends the stream
    logic out_free;    // output register can take a result this cycle
    logic final_step;  // one result left in the current burst
  } grr_status_t;

endpackage

`default_nettype wire

// ===== hdl/grr_ctrl.sv =====
// ---------------------------------------------------------------------------
// grr_ctrl
// fill/emit controller for the group reversal
// ---------------------------------------------------------------------------
`default_nettype none

module grr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  grr_pkg::grr_status_t status,
  output grr_pkg::grr_cmd_t    cmd
);

  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } state_t;

  state_t state;

  assign in_ready   = (state == ST_FILL);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.step   = (state == ST_EMIT) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      unique case (state)
        ST_FILL: begin
          if (cmd.accept && status.emit_req) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (cmd.step && status.final_step) begin
            state <= ST_FILL;
          end
        end
        default: begin
          state <= ST_FILL;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/grr_datapath.sv =====
// ---------------------------------------------------------------------------
// grr_datapath
// group buffer, fill and read counters, output register
// ---------------------------------------------------------------------------
`default_nettype none

module grr_datapath #(
  parameter int MAX_GROUP  = grr_pkg::MAX_GROUP_DEF,
  parameter int DATA_WIDTH = grr_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [grr_pkg::CFG_W-1:0]    cfg_data,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic                         stream_last,
  input  grr_pkg::grr_cmd_t            cmd,
  output grr_pkg::grr_status_t         status,
  output logic signed [DATA_WIDTH-1:0] out_value,
  output logic                         run_last,
  output logic                         stream_end,
  output logic                         out_valid,
  input  logic                         out_ready
);

  localparam int AW   = $clog2(MAX_GROUP);
  localparam int SW   = $clog2(MAX_GROUP + 1);
  localparam int CmpW = (SW > grr_pkg::CFG_W) ? SW : grr_pkg::CFG_W;
  localparam logic [SW-1:0] SizeReset =
    SW'((grr_pkg::GROUP_SIZE_RESET > MAX_GROUP) ? MAX_GROUP : grr_pkg::GROUP_SIZE_RESET);

  logic signed [DATA_WIDTH-1:0] mem [MAX_GROUP];

  logic [SW-1:0]   group_size;
  logic [SW-1:0]   fill;
  logic [SW-1:0]   remain;
  logic [AW-1:0]   rd_idx;
  logic            reverse;
  logic            end_mark;

  logic [SW-1:0]   fill_inc;
  logic            group_full;
  logic [CmpW-1:0] cfg_ext;
  logic [SW-1:0]   cfg_eff;

  // zero reads as one, anything above the buffer depth saturates
  always_comb begin
    cfg_ext = CmpW'(cfg_data);
    if (cfg_ext == '0) begin
      cfg_eff = SW'(1);
    end else if (cfg_ext > CmpW'(MAX_GROUP)) begin
      cfg_eff = SW'(MAX_GROUP);
    end else begin
      cfg_eff = SW'(cfg_ext);
    end
  end

  assign fill_inc          = fill + SW'(1);
  assign group_full        = (fill_inc >= group_size);
  assign status.emit_req   = group_full || stream_last;
  assign status.out_free   = !out_valid || out_ready;
  assign status.final_step = (remain == SW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= SizeReset;
      fill       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        group_size <= cfg_eff;
      end
      if (cmd.accept) begin
        fill <= status.emit_req ? '0 : fill_inc;
      end
      if (cmd.step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // group buffer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[fill[AW-1:0]] <= value;
    end
    if (cmd.step) begin
      out_value <= mem[rd_idx];
    end
  end

  // burst bookkeeping and result flags
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      remain   <= fill_inc;
      reverse  <= group_full;
      end_mark <= stream_last;
      rd_idx   <= group_full ? fill[AW-1:0] : '0;
    end
    if (cmd.step) begin
      run_last   <= status.final_step;
      stream_end <= status.final_step && end_mark;
      remain     <= remain - SW'(1);
      rd_idx     <= reverse ? rd_idx - AW'(1) : rd_idx + AW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/group_reverse_reorder.sv =====
// ---------------------------------------------------------------------------
// group_reverse_reorder
// reverses a stream of signed values in full groups (a short last group keeps its order) of group_size items
// ---------------------------------------------------------------------------
//
//   channel  | signals                                 | direction
//   ---------+-----------------------------------------+----------
//   input    | in_valid, in_ready, value, stream_last  | in
//   output   | out_valid, out_ready, out_value,        | out
//            | run_last, stream_end                    |
//   config   | cfg_valid, cfg_ready, cfg_data          | in
//
// an input that neither fills a group nor ends the stream is only written into the buffer
// one that does starts a burst of n results out of the group buffer, one per cycle
// while the output does not stall; input is held off until the last result is loaded
// output stalls stretch the burst; the buffer is read only where written
// reset clears state, fill count and output valid, and loads the reset group size
// the last result of a burst sits in the output register while new input is taken
// ---------------------------------------------------------------------------
`default_nettype none

module group_reverse_reorder #(
  parameter int MAX_GROUP  = grr_pkg::MAX_GROUP_DEF,
  parameter int DATA_WIDTH = grr_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input transaction
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic                         stream_last,
  // result transaction
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_value,
  output logic                         run_last,
  output logic                         stream_end,
  // group size register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [grr_pkg::CFG_W-1:0]    cfg_data
);

  grr_pkg::grr_cmd_t    cmd;
  grr_pkg::grr_status_t status;

  // register writes are always taken and land in the group size register
  assign cfg_ready = 1'b1;

  // sequencer: fill the buffer, then drain it as a burst
  grr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // buffer, counters and the output register
  grr_datapath #(
    .MAX_GROUP  (MAX_GROUP),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .value       (value),
    .stream_last (stream_last),
    .cmd         (cmd),
    .status      (status),
    .out_value   (out_value),
    .run_last    (run_last),
    .stream_end  (stream_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

endmodule

`default_nettype wire

// ===== hdl/grr_checker.sv =====
// ---------------------------------------------------------------------------
// grr_checker
// port-level checks for the group reversal block
// ---------------------------------------------------------------------------
`default_nettype none
`include "group_reverse_reorder_macros.svh"

module grr_checker #(
  parameter int DATA_WIDTH = grr_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] out_value,
  input logic                  run_last,
  input logic                  stream_end
);

  // stalled result holds
  `GRR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(run_last) && $stable(stream_end), "stalled result changed")

  // end of stream only on the last result of a burst
  `GRR_ASSERT_IMPLIES(a_end_on_run_last, clk, rst, out_valid && stream_end, run_last, "stream_end without run_last")

  // mid-burst the block takes no input
  `GRR_ASSERT_IMPLIES(a_no_input_mid_burst, clk, rst, out_valid && !run_last, !in_ready, "input taken during a burst")

endmodule

bind group_reverse_reorder grr_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_grr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_value  (out_value),
  .run_last   (run_last),
  .stream_end (stream_end)
);

`default_nettype wire
